@@ rtl/dht_pkg.sv @@
// shared constants and types for the double hashing table
`default_nettype none

package dht_pkg;

  // table geometry (prime number of slots)
  localparam int TABLE_SIZE = 1021;
  localparam int IDX_W      = $clog2(TABLE_SIZE);

  // field widths
  localparam int KEY_W  = 32;
  localparam int VAL_W  = 32;
  localparam int SLOT_W = KEY_W + VAL_W;

  // all-ones key marks an empty slot
  localparam logic [KEY_W-1:0] EMPTY_KEY = '1;

  // moduli of the two hashes
  localparam logic [KEY_W-1:0] MOD_M  = KEY_W'(TABLE_SIZE);
  localparam logic [KEY_W-1:0] MOD_M1 = KEY_W'(TABLE_SIZE - 1);

  // reciprocals floor(2^32 / m) for the quotient estimate
  localparam logic [KEY_W-1:0] RECIP_M  = KEY_W'((64'd1 << KEY_W) / TABLE_SIZE);
  localparam logic [KEY_W-1:0] RECIP_M1 = KEY_W'((64'd1 << KEY_W) / (TABLE_SIZE - 1));

  // result codes
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2,
    ST_INVALID   = 2'd3
  } status_t;

endpackage

`default_nettype wire

@@ rtl/dht_ram.sv @@
// generic single-port-write, single-port-read ram with registered read
`default_nettype none

module dht_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

@@ rtl/dht_hash.sv @@
// three-stage pipeline computing start slot (key mod m) and step (key mod (m-1) + 1)
`default_nettype none

module dht_hash (
  input  wire logic                       clk,
  input  wire logic [dht_pkg::KEY_W-1:0]  key,
  output logic      [dht_pkg::IDX_W-1:0]  start_idx,
  output logic      [dht_pkg::IDX_W-1:0]  stride
);

  import dht_pkg::*;

  logic [2*KEY_W-1:0] prod_m;
  logic [2*KEY_W-1:0] prod_m1;
  logic [KEY_W-1:0]   quot_m;
  logic [KEY_W-1:0]   quot_m1;
  logic [KEY_W-1:0]   key_s1;
  logic [KEY_W-1:0]   qm_m;
  logic [KEY_W-1:0]   qm_m1;
  logic [KEY_W-1:0]   key_s2;
  logic [KEY_W-1:0]   diff_m;
  logic [KEY_W-1:0]   diff_m1;
  logic [KEY_W-1:0]   rem_m;
  logic [KEY_W-1:0]   rem_m1;

  // stage 1: quotient estimate, low by at most one
  assign prod_m  = {{KEY_W{1'b0}}, key} * {{KEY_W{1'b0}}, RECIP_M};
  assign prod_m1 = {{KEY_W{1'b0}}, key} * {{KEY_W{1'b0}}, RECIP_M1};

  always_ff @(posedge clk) begin
    quot_m  <= prod_m[2*KEY_W-1:KEY_W];
    quot_m1 <= prod_m1[2*KEY_W-1:KEY_W];
    key_s1  <= key;
  end

  // stage 2: back-multiply, product never exceeds the key
  always_ff @(posedge clk) begin
    qm_m   <= KEY_W'(quot_m * MOD_M);
    qm_m1  <= KEY_W'(quot_m1 * MOD_M1);
    key_s2 <= key_s1;
  end

  // stage 3: remainder below twice the modulus, one correcting subtract
  always_comb begin
    diff_m  = key_s2 - qm_m;
    diff_m1 = key_s2 - qm_m1;
    rem_m   = (diff_m >= MOD_M) ? (diff_m - MOD_M) : diff_m;
    rem_m1  = (diff_m1 >= MOD_M1) ? (diff_m1 - MOD_M1) : diff_m1;
  end

  always_ff @(posedge clk) begin
    start_idx <= rem_m[IDX_W-1:0];
    stride    <= rem_m1[IDX_W-1:0] + IDX_W'(1);
  end

endmodule

`default_nettype wire

@@ rtl/double_hash_table_top.sv @@
// top level of the double hashing key/value table: control, probe loop and slot memory
//
// Open-addressed table of TABLE_SIZE slots (1021 by default), each holding a 32-bit key
// and a 32-bit value in one synchronous memory. After reset the block sweeps the memory
// to mark every slot empty, one slot a cycle, and in_ready stays low until the sweep is done.
// One item is worked at a time. An item with a valid key passes, in order, through the hash
// pipeline, one memory read set-up, one probe per cycle through the single memory read port
// (1 to TABLE_SIZE slots probed), the loading of the result register, which waits while the
// previous result is still held, and the idle state before the next acceptance.
// An all-ones key is answered with status 3 without any probe. The result sits in an output
// register, so a new item is accepted while the previous result waits for out_ready.
`default_nettype none

module double_hash_table_top (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire logic                       op,
  input  wire logic [dht_pkg::KEY_W-1:0]  key,
  input  wire logic [dht_pkg::VAL_W-1:0]  value_in,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic      [1:0]                 status,
  output logic      [dht_pkg::VAL_W-1:0]  value_out
);

  import dht_pkg::*;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_HASH,
    S_READ,
    S_CHECK,
    S_RESP
  } state_t;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_SIZE - 1);
  localparam logic [IDX_W:0]   M_EXT    = (IDX_W + 1)'(TABLE_SIZE);

  state_t            state;
  logic [1:0]        hash_cnt;
  logic [IDX_W-1:0]  clr_addr;
  logic [IDX_W-1:0]  idx;
  logic [IDX_W-1:0]  probe_cnt;
  logic              op_r;
  logic [KEY_W-1:0]  key_r;
  logic [VAL_W-1:0]  val_r;
  status_t           res_status;
  logic [VAL_W-1:0]  res_value;
  logic [1:0]        res_status_q;
  logic [VAL_W-1:0]  res_value_q;

  logic [IDX_W-1:0]  start_idx;
  logic [IDX_W-1:0]  stride;
  logic [IDX_W:0]    idx_sum;
  logic [IDX_W-1:0]  idx_next;

  logic              ram_we;
  logic [IDX_W-1:0]  ram_waddr;
  logic [SLOT_W-1:0] ram_wdata;
  logic [IDX_W-1:0]  ram_raddr;
  logic [SLOT_W-1:0] ram_rdata;

  logic [KEY_W-1:0]  slot_key;
  logic              slot_empty;
  logic              slot_hit;
  logic              last_probe;

  // hash pipeline
  dht_hash u_hash (
    .clk       (clk),
    .key       (key_r),
    .start_idx (start_idx),
    .stride    (stride)
  );

  // slot memory: key in the upper half, value in the lower half
  dht_ram #(
    .WIDTH (SLOT_W),
    .DEPTH (TABLE_SIZE)
  ) u_slots (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // next slot on the probe sequence
  always_comb begin
    idx_sum  = {1'b0, idx} + {1'b0, stride};
    idx_next = (idx_sum >= M_EXT) ? IDX_W'(idx_sum - M_EXT) : idx_sum[IDX_W-1:0];
  end

  // probe decode
  assign slot_key   = ram_rdata[SLOT_W-1:VAL_W];
  assign slot_empty = (slot_key == EMPTY_KEY);
  assign slot_hit   = (slot_key == key_r);
  assign last_probe = (probe_cnt == LAST_IDX);

  // read address: start slot on set-up, following slot while probing
  assign ram_raddr = (state == S_CHECK) ? idx_next : start_idx;

  // write port: clearing sweep or insert into the empty slot found
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = idx;
    ram_wdata = {key_r, val_r};
    if (state == S_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_addr;
      ram_wdata = {EMPTY_KEY, {VAL_W{1'b0}}};
    end else if (state == S_CHECK && !op_r && slot_empty) begin
      ram_we = 1'b1;
    end
  end

  assign in_ready  = (state == S_IDLE);
  assign status    = res_status_q;
  assign value_out = res_value_q;

  // control and registered outputs
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_addr  <= '0;
      hash_cnt  <= '0;
      probe_cnt <= '0;
      out_valid <= 1'b0;
    end else begin
      // result taken and no new one loaded this cycle
      if (out_valid && out_ready && state != S_RESP) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + IDX_W'(1);
          if (clr_addr == LAST_IDX) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            op_r     <= op;
            key_r    <= key;
            val_r    <= value_in;
            hash_cnt <= '0;
            if (key == EMPTY_KEY) begin
              res_status <= ST_INVALID;
              res_value  <= '0;
              state      <= S_RESP;
            end else begin
              state <= S_HASH;
            end
          end
        end
        S_HASH: begin
          hash_cnt <= hash_cnt + 2'd1;
          if (hash_cnt == 2'd2) begin
            state <= S_READ;
          end
        end
        S_READ: begin
          idx       <= start_idx;
          probe_cnt <= '0;
          state     <= S_CHECK;
        end
        S_CHECK: begin
          if (!op_r) begin
            // insert
            res_value <= '0;
            if (slot_empty) begin
              res_status <= ST_OK;
              state      <= S_RESP;
            end else if (last_probe) begin
              res_status <= ST_FULL;
              state      <= S_RESP;
            end else begin
              idx       <= idx_next;
              probe_cnt <= probe_cnt + IDX_W'(1);
            end
          end else begin
            // lookup
            if (slot_empty || (!slot_hit && last_probe)) begin
              res_status <= ST_NOT_FOUND;
              res_value  <= '0;
              state      <= S_RESP;
            end else if (slot_hit) begin
              res_status <= ST_OK;
              res_value  <= ram_rdata[VAL_W-1:0];
              state      <= S_RESP;
            end else begin
              idx       <= idx_next;
              probe_cnt <= probe_cnt + IDX_W'(1);
            end
          end
        end
        S_RESP: begin
          if (!out_valid || out_ready) begin
            out_valid    <= 1'b1;
            res_status_q <= res_status;
            res_value_q  <= res_value;
            state        <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // probed slot always lies inside the table
  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_CHECK) |-> ({1'b0, idx} < M_EXT))
    else $error("probe index outside table");

  // step is never zero and below the table size when probing starts
  a_stride_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_READ) |-> (stride != '0 && {1'b0, stride} < M_EXT))
    else $error("probe step out of range");

  // memory is written only by the sweep or by a completing insert
  a_write_src: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (state == S_CLEAR || (state == S_CHECK && !op_r)))
    else $error("unexpected slot write");

  // a result appears only out of the response state
  a_out_src: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_RESP))
    else $error("result without response state");

  // an insert never stores the empty marker
  a_no_empty_store: assert property (@(posedge clk) disable iff (rst)
    (ram_we && state == S_CHECK) |-> (key_r != EMPTY_KEY))
    else $error("empty marker written as key");

endmodule

`default_nettype wire
